/* rtl/core/huffman_tree_codec_assert.svh */
// ---------------------------------------------------------------------------
// Huffman tree codec assertion macros
// Concurrent check wrappers that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_CODEC_ASSERT_SVH
`define HUFFMAN_TREE_CODEC_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define HTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/htc_pkg.sv */
// ---------------------------------------------------------------------------
// Huffman tree codec package
// Actions, controller states and fixed field widths.
// ---------------------------------------------------------------------------
package htc_pkg;
   localparam int WEIGHT_W = 32;
   localparam int COUNT_W  = 24;
   localparam int SEEN_W   = 25;
   localparam int CODE_W   = 48;
   localparam int LEN_W    = 6;
   localparam logic [7:0] MARKER_RESET = 8'd20;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_BUILD  = 2'd1,
      ACT_ENCODE = 2'd2,
      ACT_DECODE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MWT,
      ST_CLEAR,
      ST_SCAN,
      ST_MERGE_A,
      ST_MERGE_B,
      ST_ENC
   } state_type;
endpackage

/* rtl/core/huffman_tree_codec.sv */
// ---------------------------------------------------------------------------
// Huffman tree codec
// Leaf weight load, tree build, symbol encode and bit-serial decode over
// node memories.
// ---------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// req_    | in  | symbol 8, count_value 24, coded_bit 1, pad 7 | action 2
// rsp_    | out | result_symbol 8, code_value 48, code_length 6,| symbol_valid 1
//         |     | end_reached 1, tree_ready 1                  |
// csr_    | in  | end_marker_symbol 8                          | -
//
// Decode takes one bit per cycle while the result is not stalled: the children of
// the current node sit in the child memory read register, refetched with each bit.
// A load is followed by a refetch of the marker's weight (ST_IDLE read, then ST_MWT
// capture), as after a marker write; encode walks up from the leaf one tree level per step.
// Build: a clear sweep of the parent memory, then per merge a scan below pos and two writes.
// Synchronous reset; a stalled result holds the block in its current step.
// ---------------------------------------------------------------------------
`include "huffman_tree_codec_assert.svh"
module huffman_tree_codec
   import htc_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int NODE_COUNT   = 511
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // symbol, count_value, coded_bit, zero pad
   input  logic [1:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // result_symbol, code_value, code_length,
                                   // end_reached, tree_ready
   output logic [0:0]  rsp_tuser,  // symbol_valid
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata   // end_marker_symbol
);
   localparam int NW   = $clog2(NODE_COUNT + 1);
   localparam int SW   = $clog2(SYMBOL_COUNT);
   localparam int INT  = NODE_COUNT - SYMBOL_COUNT;
   localparam int IW   = (INT > 1) ? $clog2(INT) : 1;
   localparam int PW   = NW + 2;
   localparam logic [NW-1:0] ROOT = NW'(NODE_COUNT - 1);
   localparam logic [NW-1:0] SLIM = NW'(SYMBOL_COUNT);
   localparam logic [NW-1:0] NLIM = NW'(NODE_COUNT);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_W);
   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

   // memories
   logic [WEIGHT_W-1:0] weight_mem [NODE_COUNT];
   logic [PW-1:0]       parent_mem [NODE_COUNT];
   logic [2*NW-1:0]     child_mem  [INT];
   logic [WEIGHT_W-1:0] w_rd_ff;
   logic [PW-1:0]       p_rd_ff;
   logic [2*NW-1:0]     c_rd_ff;

   logic w_we, w_re, p_we, p_re, c_we, c_re;
   logic [NW-1:0] w_wa, w_ra, p_wa, p_ra;
   logic [IW-1:0] c_wa, c_ra;
   logic [WEIGHT_W-1:0] w_wd;
   logic [PW-1:0] p_wd;
   logic [2*NW-1:0] c_wd;

   // control and data registers
   state_type state_ff, state_in;
   logic [SYMBOL_COUNT-1:0] loaded_ff;
   logic [7:0] marker_ff;
   logic [WEIGHT_W-1:0] mwt_ff;
   logic stale_ff, built_ff, fin_ff;
   logic [SEEN_W-1:0] seen_ff;
   logic [NW-1:0] pos_ff, scan_idx_ff, scan_rix_ff, clr_idx_ff;
   logic scan_vld_ff;
   logic [1:0] found_ff;
   logic [WEIGHT_W-1:0] min1_w_ff, min2_w_ff;
   logic [NW-1:0] min1_i_ff, min2_i_ff;
   logic [CODE_W-1:0] code_ff, mask_ff;
   logic [LEN_W-1:0] len_ff;
   logic out_vld_ff, o_sv_ff, o_end_ff, o_rdy_ff;
   logic [7:0] o_sym_ff;
   logic [CODE_W-1:0] o_code_ff;
   logic [LEN_W-1:0] o_len_ff;

   // request fields
   logic accept, out_free, sym_ok;
   action_type act;
   logic [7:0] sym;
   logic [COUNT_W-1:0] cnt;
   logic cbit;
   assign act      = action_type'(req_tuser);
   assign sym      = req_tdata[7:0];
   assign cnt      = req_tdata[31:8];
   assign cbit     = req_tdata[32];
   assign out_free = !out_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !stale_ff && out_free;
   assign accept   = req_tvalid && req_tready;
   assign sym_ok   = 16'(sym) < 16'(SYMBOL_COUNT);

   // masked weight from the read stage: unloaded leaves read zero
   logic [WEIGHT_W-1:0] w_eff;
   always_comb begin
      w_eff = w_rd_ff;
      if (scan_rix_ff < SLIM && !loaded_ff[scan_rix_ff[SW-1:0]]) begin
         w_eff = '0;
      end
   end

   // decode step from the prefetched children
   logic [NW-1:0] nxt0, nxt;
   logic is_leaf, is_mark, is_final;
   logic [SEEN_W-1:0] seen_inc;
   always_comb begin
      nxt0     = cbit ? c_rd_ff[2*NW-1:NW] : c_rd_ff[NW-1:0];
      nxt      = (nxt0 >= NLIM) ? ROOT : nxt0;
      is_leaf  = nxt < SLIM;
      is_mark  = is_leaf && (16'(nxt) == 16'(marker_ff));
      seen_inc = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;
      is_final = is_mark && (WEIGHT_W'(seen_inc) >= mwt_ff);
   end

   // scan end and encode step views
   logic scan_done;
   logic p_has, p_br;
   logic [NW-1:0] p_par;
   assign scan_done = (scan_idx_ff == pos_ff) && !scan_vld_ff;
   assign p_has = p_rd_ff[NW+1];
   assign p_br  = p_rd_ff[NW];
   assign p_par = p_rd_ff[NW-1:0];

   // next state, memory strobes and result
   logic emit, e_sv, built_in, fin_in;
   logic [7:0] e_sym;
   logic [CODE_W-1:0] e_code;
   logic [LEN_W-1:0] e_len;
   always_comb begin
      state_in = state_ff;
      w_we = 1'b0; w_wa = '0; w_wd = '0; w_re = 1'b0; w_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_re = 1'b0; p_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_re = 1'b0; c_ra = '0;
      emit = 1'b0; e_sv = 1'b0; e_sym = '0; e_code = '0; e_len = '0;
      built_in = built_ff; fin_in = fin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stale_ff) begin
               w_re = 1'b1;
               w_ra = NW'(marker_ff);
               state_in = ST_MWT;
            end else if (accept) begin
               case (act)
                  ACT_LOAD: begin
                     emit = 1'b1;
                     if (sym_ok) begin
                        w_we = 1'b1;
                        w_wa = NW'(sym);
                        w_wd = WEIGHT_W'(cnt);
                        built_in = 1'b0;
                     end
                  end
                  ACT_BUILD: begin
                     built_in = 1'b0;
                     fin_in = 1'b0;
                     state_in = ST_CLEAR;
                  end
                  ACT_ENCODE: begin
                     if (built_ff && sym_ok) begin
                        p_re = 1'b1;
                        p_ra = NW'(sym);
                        state_in = ST_ENC;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                     if (built_ff && !fin_ff) begin
                        c_re = 1'b1;
                        if (is_leaf) begin
                           c_ra = IW'(ROOT - SLIM);
                           if (is_final) begin
                              fin_in = 1'b1;
                           end else begin
                              e_sv = 1'b1;
                              e_sym = 8'(nxt);
                           end
                        end else begin
                           c_ra = IW'(nxt - SLIM);
                        end
                     end
                  end
               endcase
            end
         end
         ST_MWT: state_in = ST_IDLE;
         ST_CLEAR: begin
            p_we = 1'b1;
            p_wa = clr_idx_ff;
            if (clr_idx_ff == ROOT) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_idx_ff != pos_ff) begin
               w_re = 1'b1; w_ra = scan_idx_ff;
               p_re = 1'b1; p_ra = scan_idx_ff;
            end
            if (scan_done) begin
               if (found_ff == 2'd2) begin
                  state_in = ST_MERGE_A;
               end else if (out_free) begin
                  emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MERGE_A: begin
            w_we = 1'b1; w_wa = pos_ff; w_wd = min1_w_ff + min2_w_ff;
            c_we = 1'b1; c_wa = IW'(pos_ff - SLIM); c_wd = {min2_i_ff, min1_i_ff};
            p_we = 1'b1; p_wa = min1_i_ff; p_wd = {1'b1, 1'b0, pos_ff};
            state_in = ST_MERGE_B;
         end
         ST_MERGE_B: begin
            if (pos_ff != ROOT || out_free) begin
               p_we = 1'b1; p_wa = min2_i_ff; p_wd = {1'b1, 1'b1, pos_ff};
               if (pos_ff == ROOT) begin
                  c_re = 1'b1;
                  c_ra = IW'(ROOT - SLIM);
                  built_in = 1'b1;
                  emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ENC: begin
            if (!p_has || len_ff == LEN_MAX) begin
               if (out_free) begin
                  emit = 1'b1;
                  if (!p_has) begin
                     e_code = code_ff;
                     e_len = len_ff;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               p_re = 1'b1;
               p_ra = p_par;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_wa] <= w_wd;
      if (w_re) w_rd_ff <= weight_mem[w_ra];
      if (p_we) parent_mem[p_wa] <= p_wd;
      if (p_re) p_rd_ff <= parent_mem[p_ra];
      if (c_we) child_mem[c_wa] <= c_wd;
      if (c_re) c_rd_ff <= child_mem[c_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= '0;
         marker_ff  <= MARKER_RESET;
         stale_ff   <= 1'b1;
         built_ff   <= 1'b0;
         fin_ff     <= 1'b0;
         seen_ff    <= '0;
         out_vld_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         built_ff <= built_in;
         fin_ff   <= fin_in;
         if (csr_we) marker_ff <= csr_wdata;
         // refetch the marker weight after a marker write or a leaf load
         if (csr_we || (w_we && state_ff == ST_IDLE)) begin
            stale_ff <= 1'b1;
         end else if (state_ff == ST_MWT) begin
            stale_ff <= 1'b0;
         end
         if (w_we && state_ff == ST_IDLE) begin
            loaded_ff[w_wa[SW-1:0]] <= 1'b1;
         end
         if (accept && act == ACT_BUILD) seen_ff <= '0;
         else if (accept && act == ACT_DECODE && built_ff && !fin_ff && is_mark) begin
            seen_ff <= seen_inc;
         end
         scan_vld_ff <= (state_ff == ST_SCAN) && (scan_idx_ff != pos_ff);
         if (emit) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // capture marker weight
      if (state_ff == ST_IDLE && stale_ff) scan_rix_ff <= NW'(marker_ff);
      if (state_ff == ST_MWT) mwt_ff <= w_eff;
      // clear sweep
      if (accept && act == ACT_BUILD) clr_idx_ff <= '0;
      else if (state_ff == ST_CLEAR) clr_idx_ff <= clr_idx_ff + 1'b1;
      // scan and merge bookkeeping
      if (state_ff == ST_CLEAR && clr_idx_ff == ROOT) begin
         pos_ff <= SLIM;
         scan_idx_ff <= '0;
         found_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (scan_idx_ff != pos_ff) begin
            scan_rix_ff <= scan_idx_ff;
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (scan_vld_ff && !p_rd_ff[NW+1]) begin
            if (found_ff == 2'd0 || w_eff < min1_w_ff) begin
               min2_w_ff <= min1_w_ff; min2_i_ff <= min1_i_ff;
               min1_w_ff <= w_eff;     min1_i_ff <= scan_rix_ff;
               if (found_ff != 2'd2) found_ff <= found_ff + 1'b1;
            end else if (found_ff == 2'd1 || w_eff < min2_w_ff) begin
               min2_w_ff <= w_eff; min2_i_ff <= scan_rix_ff;
               found_ff <= 2'd2;
            end
         end
      end
      if (state_ff == ST_MERGE_B && state_in == ST_SCAN) begin
         pos_ff <= pos_ff + 1'b1;
         scan_idx_ff <= '0;
         found_ff <= '0;
      end
      // encode walk
      if (accept && act == ACT_ENCODE) begin
         code_ff <= '0;
         mask_ff <= CODE_W'(1);
         len_ff <= '0;
      end else if (state_ff == ST_ENC && p_re) begin
         code_ff <= code_ff | (mask_ff & {CODE_W{p_br}});
         mask_ff <= mask_ff << 1;
         len_ff <= len_ff + 1'b1;
      end
      // result register
      if (emit) begin
         o_sym_ff  <= e_sym;
         o_sv_ff   <= e_sv;
         o_code_ff <= e_code;
         o_len_ff  <= e_len;
         o_end_ff  <= fin_in;
         o_rdy_ff  <= built_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {o_rdy_ff, o_end_ff, o_len_ff, o_code_ff, o_sym_ff};
   assign rsp_tuser  = o_sv_ff;

   `HTC_ASSERT_NOW(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE)
   `HTC_ASSERT_NOW(a_sym_not_end, clock, reset, out_vld_ff && o_sv_ff, !o_end_ff)
   `HTC_ASSERT_NOW(a_merge_two, clock, reset, state_ff == ST_MERGE_A, found_ff == 2'd2)
   `HTC_ASSERT_NOW(a_enc_len, clock, reset, state_ff == ST_ENC, len_ff <= LEN_MAX)
endmodule

/* verif/huffman_tree_codec_tb.sv */
// ---------------------------------------------------------------------------
// Huffman tree codec testbench
// Drives load, build, encode and decode beats through the request stream and
// checks every response beat against a tree predictor kept in step with the
// stimulus. Phases vary the end marker, the leaf weights and the idle mix.
// ---------------------------------------------------------------------------
module huffman_tree_codec_tb;
   import htc_pkg::*;

   localparam int N_SYM       = 256;
   localparam int N_NODE      = 511;
   localparam int ROOT        = N_NODE - 1;
   localparam int MAX_BITS    = 48;
   localparam int SEEN_MAX    = 32'h1FF_FFFF;
   localparam int QUIET_LIMIT = 400000;
   localparam int HOLD_CYCLES = 600;
   localparam int PHASE_ITEMS = 185;

   typedef struct {
      action_type  act;
      logic [7:0]  sym;
      logic [23:0] cnt;
      logic        cbit;
   } codec_req_type;

   typedef struct {
      logic [7:0]  rsym;
      logic        sym_ok;
      logic [47:0] code;
      logic [5:0]  len;
      logic        done;
      logic        ready;
   } codec_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   codec_req_type pending_q[$];
   codec_rsp_type expected_q[$];
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   bit         pressure_on = 0;
   bit         hold_done = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         mismatches = 0;
   int         sent_items = 0;

   // tree predictor state
   logic [31:0] weight_m[N_NODE];
   bit          valid_m[N_NODE];
   bit          linked_m[N_NODE];
   logic [8:0]  parent_m[N_NODE];
   bit          branch_m[N_NODE];
   logic [8:0]  left_m[N_NODE];
   logic [8:0]  right_m[N_NODE];
   int          walk_pos;
   int unsigned marker_hits;
   bit          decode_done;
   bit          tree_ok;
   logic [7:0]  marker_sym;

   huffman_tree_codec uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // lowest-index free node of least weight below limit, -1 if none
   function automatic int lightest_free(input int limit);
      int best;
      best = -1;
      for (int i = 0; i < limit; i++) begin
         if (valid_m[i] && !linked_m[i]) begin
            if (best < 0 || weight_m[i] < weight_m[best]) best = i;
         end
      end
      return best;
   endfunction

   function automatic void grow_tree();
      int a;
      int b;
      for (int i = N_SYM; i < N_NODE; i++) begin
         valid_m[i] = 0;
         weight_m[i] = '0;
      end
      for (int i = 0; i < N_NODE; i++) begin
         linked_m[i] = 0;
         branch_m[i] = 0;
      end
      walk_pos = ROOT;
      marker_hits = 0;
      decode_done = 0;
      tree_ok = 0;
      for (int p = N_SYM; p < N_NODE; p++) begin
         a = lightest_free(p);
         if (a < 0) return;
         linked_m[a] = 1;
         b = lightest_free(p);
         if (b < 0) return;
         linked_m[b] = 1;
         parent_m[a] = p[8:0];
         parent_m[b] = p[8:0];
         branch_m[a] = 0;
         branch_m[b] = 1;
         weight_m[p] = weight_m[a] + weight_m[b];
         valid_m[p] = 1;
         left_m[p] = a[8:0];
         right_m[p] = b[8:0];
      end
      tree_ok = 1;
   endfunction

   // leaf-to-root walk; code right aligned, first bit in the top used bit
   function automatic void code_of(input int s, output logic [47:0] c, output int n);
      int node;
      int steps;
      bit over;
      c = '0;
      n = 0;
      node = s;
      steps = 0;
      over = 0;
      if (!tree_ok) return;
      while (node < N_NODE && linked_m[node] && steps < N_NODE) begin
         if (n >= MAX_BITS) begin
            over = 1;
            break;
         end
         c[n] = branch_m[node];
         n++;
         node = parent_m[node];
         steps++;
      end
      if (over) begin
         c = '0;
         n = 0;
      end
   endfunction

   function automatic codec_rsp_type predict_beat(input codec_req_type it);
      codec_rsp_type r;
      int n;
      int nxt;
      int pos;
      bit last_marker;
      r = '{default: '0};
      case (it.act)
         ACT_LOAD: begin
            weight_m[it.sym] = {8'd0, it.cnt};
            tree_ok = 0;
         end
         ACT_BUILD: grow_tree();
         ACT_ENCODE: begin
            code_of(it.sym, r.code, n);
            r.len = n[5:0];
         end
         default: begin
            if (tree_ok && !decode_done) begin
               pos = walk_pos;
               if (pos < N_SYM || pos >= N_NODE) pos = ROOT;
               nxt = it.cbit ? right_m[pos] : left_m[pos];
               if (nxt < N_SYM) begin
                  last_marker = 0;
                  if (nxt == marker_sym) begin
                     if (marker_hits < SEEN_MAX) marker_hits++;
                     if (marker_hits >= weight_m[nxt]) last_marker = 1;
                  end
                  if (last_marker) decode_done = 1;
                  else begin
                     r.rsym = nxt[7:0];
                     r.sym_ok = 1;
                  end
                  walk_pos = ROOT;
               end else begin
                  walk_pos = nxt;
               end
            end
         end
      endcase
      r.done = decode_done;
      r.ready = tree_ok;
      return r;
   endfunction

   task automatic push_req(input action_type act, input int s, input int c, input bit b);
      codec_req_type it;
      it.act = act;
      it.sym = s[7:0];
      it.cnt = c[23:0];
      it.cbit = b;
      expected_q.push_back(predict_beat(it));
      pending_q.push_back(it);
      sent_items++;
   endtask

   // feed the code bits of one symbol, most significant first
   task automatic send_symbol_bits(input int s);
      logic [47:0] c;
      int n;
      code_of(s, c, n);
      if (n == 0) push_req(ACT_DECODE, 0, $urandom, $urandom_range(1));
      for (int i = n - 1; i >= 0; i--) push_req(ACT_DECODE, 0, $urandom, c[i]);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_marker(input logic [7:0] v);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      marker_sym = v;
      repeat (3) @(posedge clock);
   endtask

   function automatic int pick_weight();
      case ($urandom_range(3))
         0: return 0;
         1: return 24'hFF_FFFF;
         2: return $urandom_range(15);
         default: return $urandom & 24'hFF_FFFF;
      endcase
   endfunction

   // request driver: hold the beat until accepted, then maybe idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            codec_req_type it;
            it = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, it.cbit, it.cnt, it.sym};
            req_tuser <= it.act;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: one long hold-off when asked, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (pressure_on && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         codec_rsp_type got;
         codec_rsp_type want;
         got.rsym = rsp_tdata[7:0];
         got.code = rsp_tdata[55:8];
         got.len = rsp_tdata[61:56];
         got.done = rsp_tdata[62];
         got.ready = rsp_tdata[63];
         got.sym_ok = rsp_tuser[0];
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_tdata);
         end else begin
            want = expected_q.pop_front();
            if (got.rsym !== want.rsym || got.sym_ok !== want.sym_ok ||
                got.code !== want.code || got.len !== want.len ||
                got.done !== want.done || got.ready !== want.ready) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp sym %0d/%0b code %h/%0d end %0b rdy %0b, got sym %0d/%0b code %h/%0d end %0b rdy %0b",
                           want.rsym, want.sym_ok, want.code, want.len, want.done, want.ready,
                           got.rsym, got.sym_ok, got.code, got.len, got.done, got.ready);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[huffman_tree_codec] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_items;
      int fib_a;
      int fib_b;
      int fib_c;
      int s;
      int markers[6];
      int pct_send[4];
      int pct_stall[4];

      // predictor reset
      for (int i = 0; i < N_NODE; i++) begin
         weight_m[i] = '0;
         valid_m[i] = (i < N_SYM);
         linked_m[i] = 0;
         parent_m[i] = '0;
         branch_m[i] = 0;
         left_m[i] = '0;
         right_m[i] = '0;
      end
      walk_pos = ROOT;
      marker_hits = 0;
      decode_done = 0;
      tree_ok = 0;
      marker_sym = MARKER_RESET;
      markers = '{0, 255, 20, 128, 0, 0};
      markers[5] = $urandom_range(255);
      pct_send = '{0, 72, 0, 31};
      pct_stall = '{0, 0, 72, 31};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: no tree, extremes, marker twice, load after build
      push_req(ACT_DECODE, 0, 0, 1);
      push_req(ACT_ENCODE, 0, 0, 0);
      push_req(ACT_LOAD, 0, 0, 0);
      push_req(ACT_LOAD, 255, 24'hFF_FFFF, 1);
      push_req(ACT_LOAD, 20, 2, 0);
      push_req(ACT_LOAD, 7, 5, 0);
      push_req(ACT_LOAD, 100, 1, 0);
      push_req(ACT_BUILD, 0, 0, 0);
      push_req(ACT_ENCODE, 0, 0, 0);
      push_req(ACT_ENCODE, 255, 0, 0);
      push_req(ACT_ENCODE, 20, 0, 0);
      send_symbol_bits(255);
      send_symbol_bits(0);
      send_symbol_bits(20);
      send_symbol_bits(20);
      push_req(ACT_DECODE, 0, 0, 1);
      push_req(ACT_LOAD, 3, 9, 0);
      push_req(ACT_ENCODE, 255, 0, 0);
      push_req(ACT_DECODE, 0, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         write_marker(markers[ph][7:0]);
         send_idle_pct = pct_send[ph % 4];
         stall_pct = pct_stall[ph % 4];
         phase_items = sent_items;
         if (ph == 3) begin
            // Fibonacci weights stretch the tree as deep as it goes
            fib_a = 0;
            fib_b = 1;
            for (int k = 0; k < 40; k++) begin
               push_req(ACT_LOAD, k, fib_b, 0);
               fib_c = fib_a + fib_b;
               if (fib_c > 24'hFF_FFFF) fib_c = 24'hFF_FFFF;
               fib_a = fib_b;
               fib_b = fib_c;
            end
         end else begin
            repeat ($urandom_range(30, 60)) begin
               push_req(ACT_LOAD, $urandom_range(255), pick_weight(), 0);
            end
         end
         push_req(ACT_LOAD, markers[ph], $urandom_range(3), 0);
         push_req(ACT_BUILD, 0, 0, 0);
         if (ph == 0) begin
            // backlog the core behind a long response hold-off
            wait_drained();
            pressure_on = 1;
         end
         while (sent_items - phase_items < PHASE_ITEMS) begin
            s = $urandom_range(99);
            if (s < 70) begin
               send_symbol_bits(($urandom_range(2) == 0) ? markers[ph] : $urandom_range(255));
            end else if (s < 85) begin
               push_req(ACT_ENCODE, $urandom_range(255), $urandom, $urandom_range(1));
            end else if (s < 97) begin
               push_req(ACT_DECODE, $urandom_range(255), $urandom, $urandom_range(1));
            end else begin
               push_req(ACT_LOAD, $urandom_range(255), pick_weight(), 0);
            end
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("[huffman_tree_codec] OK");
      end else begin
         $display("[huffman_tree_codec] ERROR");
      end
      $finish;
   end
endmodule
